[sv/wav_hdr_pkg.sv]
// Package for the WAV header parser: chunk ids, size limits, codes and the
// result word layout. No dependencies.

package wav_hdr_pkg;

  // Width of the running byte counter (16 to 32)
  localparam int POSITION_BITS = 32;

  // Chunk ids as they build up little-endian in the id shift register
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] ID_DATA = 32'h6174_6164;  // "data"

  localparam int MIN_FILE_BYTES = 44;
  localparam int MIN_FMT_BYTES  = 16;
  localparam int HDR_BYTES      = 12;

  // fmt body index saturates once the fields of interest are past
  localparam int BODY_IDX_W = $clog2(MIN_FMT_BYTES + 1);

  // Result word: status, is_stereo, rate_hz, data_offset, data_bytes,
  // sample_frames, zero padding up to whole bytes
  localparam int RESULT_FIELDS_W = 3 + 1 + 32 + 32 + 32 + 30;
  localparam int RESULT_W        = ((RESULT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_TAG     = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_NO_DATA     = 3'd4,
    ST_TOO_LONG    = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_ID   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_BODY = 5'b01000,
    PH_PAD  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [RESULT_W-RESULT_FIELDS_W-1:0] pad;
    logic [29:0]                         sample_frames;
    logic [31:0]                         data_bytes;
    logic [31:0]                         data_offset;
    logic [31:0]                         rate_hz;
    logic                                is_stereo;
    status_t                             status;
  } result_t;

  // Expected RIFF/WAVE header byte; bit 8 set where the byte is checked
  function automatic logic [8:0] hdr_tag(input logic [3:0] idx);
    logic [8:0] tag;
    case (idx)
      4'd0:    tag = {1'b1, 8'h52};  // R
      4'd1:    tag = {1'b1, 8'h49};  // I
      4'd2:    tag = {1'b1, 8'h46};  // F
      4'd3:    tag = {1'b1, 8'h46};  // F
      4'd8:    tag = {1'b1, 8'h57};  // W
      4'd9:    tag = {1'b1, 8'h41};  // A
      4'd10:   tag = {1'b1, 8'h56};  // V
      4'd11:   tag = {1'b1, 8'h45};  // E
      default: tag = {1'b0, 8'h00};  // RIFF size field, not checked
    endcase
    return tag;
  endfunction

endpackage

[sv/wav_header_parser_unit.sv]
// WAV header parser top level: walks RIFF/WAVE chunks byte by byte and
// reports format and data chunk info on the final byte.
// Depends on wav_hdr_pkg.

// Result: the result of an accepted final byte is registered and shows in the next cycle.
// Throughput: one file byte per cycle unless stalled; every byte is handled by the
// combinational parse step between the input and the result register.
// Input words stall whenever a result is waiting at the output and m_tready
// is low. Reset (rst, synchronous) returns the parser to the
// start of a file; each accepted final byte does the same.
module wav_header_parser_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // file_byte
  input  logic                             s_tlast,   // final_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[2:0], is_stereo[3], rate_hz[35:4], data_offset[67:36],
  // data_bytes[99:68], sample_frames[129:100], zero pad
  output logic [wav_hdr_pkg::RESULT_W-1:0] m_tdata
);
  import wav_hdr_pkg::*;

  localparam int P = POSITION_BITS;

  // Parse state
  logic [P-1:0]          byte_position, byte_position_next;
  phase_t                phase, phase_next;
  logic                  tag_ok, tag_ok_next;
  logic                  pos_overflow, pos_overflow_next;
  logic [1:0]            field_cnt, field_cnt_next;
  logic [31:0]           chunk_id, chunk_id_next;
  logic [31:0]           chunk_length, chunk_length_next;
  logic [31:0]           chunk_remaining, chunk_remaining_next;
  logic [BODY_IDX_W-1:0] body_idx, body_idx_next;
  logic [P-1:0]          body_start, body_start_next;

  // fmt fields being collected from the current chunk
  logic [15:0] pend_code, pend_code_next;
  logic [15:0] pend_chans, pend_chans_next;
  logic [31:0] pend_rate, pend_rate_next;
  logic [15:0] pend_bits, pend_bits_next;

  // Fields from the last complete fmt and data chunks
  logic        fmt_ok, fmt_ok_next;
  logic        fmt_stereo, fmt_stereo_next;
  logic [31:0] fmt_rate, fmt_rate_next;
  logic [P-1:0] data_offset, data_offset_next;
  logic [31:0] data_bytes, data_bytes_next;

  logic    accept;
  logic    file_end;
  result_t res, res_next;
  logic [30:0] half_bytes;
  logic [8:0]  tag_exp;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign file_end = accept && s_tlast;
  assign m_tdata  = res;

  // Parse step for one byte
  always_comb begin
    tag_exp              = hdr_tag(byte_position[3:0]);
    byte_position_next   = byte_position + P'(1);
    pos_overflow_next    = pos_overflow || (byte_position == {P{1'b1}});
    phase_next           = phase;
    tag_ok_next          = tag_ok;
    field_cnt_next       = field_cnt;
    chunk_id_next        = chunk_id;
    chunk_length_next    = chunk_length;
    chunk_remaining_next = chunk_remaining;
    body_idx_next        = body_idx;
    body_start_next      = body_start;
    pend_code_next       = pend_code;
    pend_chans_next      = pend_chans;
    pend_rate_next       = pend_rate;
    pend_bits_next       = pend_bits;
    fmt_ok_next          = fmt_ok;
    fmt_stereo_next      = fmt_stereo;
    fmt_rate_next        = fmt_rate;
    data_offset_next     = data_offset;
    data_bytes_next      = data_bytes;

    case (phase)
      PH_HDR: begin
        if (byte_position < P'(HDR_BYTES)) begin
          if (tag_exp[8] && s_tdata != tag_exp[7:0]) begin
            tag_ok_next = 1'b0;
          end
        end
        if (byte_position >= P'(HDR_BYTES - 1)) begin
          phase_next     = PH_ID;
          field_cnt_next = 2'd0;
        end
      end
      PH_ID: begin
        chunk_id_next  = {s_tdata, chunk_id[31:8]};
        field_cnt_next = field_cnt + 2'd1;
        if (field_cnt == 2'd3) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        chunk_length_next = {s_tdata, chunk_length[31:8]};
        field_cnt_next    = field_cnt + 2'd1;
        if (field_cnt == 2'd3) begin
          pend_code_next  = '0;
          pend_chans_next = '0;
          pend_rate_next  = '0;
          pend_bits_next  = '0;
          body_idx_next   = '0;
          body_start_next = byte_position_next;
          if (chunk_length_next == 32'd0) begin
            // Empty chunk ends at once; an empty data chunk still commits
            if (chunk_id == ID_DATA) begin
              data_offset_next = byte_position_next;
              data_bytes_next  = 32'd0;
            end
            phase_next     = PH_ID;
            field_cnt_next = 2'd0;
          end else begin
            phase_next           = PH_BODY;
            chunk_remaining_next = chunk_length_next;
          end
        end
      end
      PH_BODY: begin
        // Collect fmt fields from the first bytes of the body
        if (chunk_id == ID_FMT) begin
          case (body_idx)
            BODY_IDX_W'(0):  pend_code_next[7:0]   = s_tdata;
            BODY_IDX_W'(1):  pend_code_next[15:8]  = s_tdata;
            BODY_IDX_W'(2):  pend_chans_next[7:0]  = s_tdata;
            BODY_IDX_W'(3):  pend_chans_next[15:8] = s_tdata;
            BODY_IDX_W'(4):  pend_rate_next[7:0]   = s_tdata;
            BODY_IDX_W'(5):  pend_rate_next[15:8]  = s_tdata;
            BODY_IDX_W'(6):  pend_rate_next[23:16] = s_tdata;
            BODY_IDX_W'(7):  pend_rate_next[31:24] = s_tdata;
            BODY_IDX_W'(14): pend_bits_next[7:0]   = s_tdata;
            BODY_IDX_W'(15): pend_bits_next[15:8]  = s_tdata;
            default: ;
          endcase
        end
        if (body_idx != BODY_IDX_W'(MIN_FMT_BYTES)) begin
          body_idx_next = body_idx + BODY_IDX_W'(1);
        end
        chunk_remaining_next = chunk_remaining - 32'd1;
        // Last body byte: commit the chunk and move on
        if (chunk_remaining == 32'd1) begin
          if (chunk_id == ID_FMT) begin
            if (chunk_length >= 32'(MIN_FMT_BYTES)) begin
              fmt_ok_next = (pend_code_next == 16'd1) &&
                            (pend_chans_next == 16'd1 || pend_chans_next == 16'd2) &&
                            (pend_bits_next == 16'd16);
              fmt_stereo_next = (pend_chans_next == 16'd2);
              fmt_rate_next   = pend_rate_next;
            end
          end else if (chunk_id == ID_DATA) begin
            data_offset_next = body_start;
            data_bytes_next  = chunk_length;
          end
          phase_next     = chunk_length[0] ? PH_PAD : PH_ID;
          field_cnt_next = 2'd0;
        end
      end
      default: begin
        // Pad byte after an odd-length body
        phase_next     = PH_ID;
        field_cnt_next = 2'd0;
      end
    endcase
  end

  // Result for a final byte, from the state after that byte
  always_comb begin
    half_bytes = data_bytes_next[31:1];
    res_next   = '0;
    if (pos_overflow_next) begin
      res_next.status = ST_TOO_LONG;
    end else if (byte_position_next < P'(MIN_FILE_BYTES)) begin
      res_next.status = ST_TOO_SHORT;
    end else if (!tag_ok_next) begin
      res_next.status = ST_BAD_TAG;
    end else if (!fmt_ok_next) begin
      res_next.status = ST_UNSUPPORTED;
    end else if (data_bytes_next == 32'd0) begin
      res_next.status = ST_NO_DATA;
    end else begin
      res_next.status      = ST_OK;
      res_next.is_stereo   = fmt_stereo_next;
      res_next.rate_hz     = fmt_rate_next;
      res_next.data_offset = 32'(data_offset_next);
      res_next.data_bytes  = data_bytes_next;
      if (fmt_stereo_next) begin
        res_next.sample_frames = data_bytes_next[31:2];
      end else begin
        res_next.sample_frames = half_bytes[30] ? {30{1'b1}} : half_bytes[29:0];
      end
    end
  end

  // Parse state registers; a final byte starts a new file
  always_ff @(posedge clk) begin
    if (rst || file_end) begin
      byte_position   <= '0;
      phase           <= PH_HDR;
      tag_ok          <= 1'b1;
      pos_overflow    <= 1'b0;
      field_cnt       <= '0;
      chunk_id        <= '0;
      chunk_length    <= '0;
      chunk_remaining <= '0;
      body_idx        <= '0;
      body_start      <= '0;
      pend_code       <= '0;
      pend_chans      <= '0;
      pend_rate       <= '0;
      pend_bits       <= '0;
      fmt_ok          <= 1'b0;
      fmt_stereo      <= 1'b0;
      fmt_rate        <= '0;
      data_offset     <= '0;
      data_bytes      <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      phase           <= phase_next;
      tag_ok          <= tag_ok_next;
      pos_overflow    <= pos_overflow_next;
      field_cnt       <= field_cnt_next;
      chunk_id        <= chunk_id_next;
      chunk_length    <= chunk_length_next;
      chunk_remaining <= chunk_remaining_next;
      body_idx        <= body_idx_next;
      body_start      <= body_start_next;
      pend_code       <= pend_code_next;
      pend_chans      <= pend_chans_next;
      pend_rate       <= pend_rate_next;
      pend_bits       <= pend_bits_next;
      fmt_ok          <= fmt_ok_next;
      fmt_stereo      <= fmt_stereo_next;
      fmt_rate        <= fmt_rate_next;
      data_offset     <= data_offset_next;
      data_bytes      <= data_bytes_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (file_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (file_end) begin
      res <= res_next;
    end
  end

  // Checks
  a_restart: assert property (@(posedge clk) disable iff (rst)
    file_end |=> (byte_position == '0) && (phase == PH_HDR) && tag_ok)
    else $error("parser did not restart after final byte");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.status != ST_OK) |->
      !res.is_stereo && (res.rate_hz == '0) && (res.data_offset == '0) &&
      (res.data_bytes == '0) && (res.sample_frames == '0))
    else $error("error result carries nonzero fields");

  a_ok_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.status == ST_OK) |-> (res.data_bytes != '0))
    else $error("ok result with empty data chunk");

  a_body_cnt: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (chunk_remaining != '0))
    else $error("body phase with no bytes left");

endmodule
